### src/tca_pkg.sv
// Shared constants for the tilt compensated attitude block.
// Holds the CORDIC arctangent table and the gain correction factor.
`default_nettype none
package tca_pkg;
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANG_OUT_WIDTH     = 16;
	localparam int ZW                = 34;
	localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

	function automatic logic [31:0] atan_tab(input int i);
		logic [31:0] r;
		unique case (i)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
			15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
			21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
			24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
			27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### src/tca_cordic.sv
// Pipelined CORDIC, vectoring or rotation, one register per iteration.
// Optional two-stage gain removal on x and y. Uses tca_pkg.
`default_nettype none
module tca_cordic #(
	parameter int W      = 20,
	parameter int STAGES = 16,
	parameter bit VEC    = 1'b1,
	parameter bit GAIN   = 1'b0,
	parameter int PW     = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic signed [W-1:0]      in_x,
	input  wire logic signed [W-1:0]      in_y,
	input  wire logic [31:0]              in_z,
	input  wire logic [PW-1:0]            in_side,
	output logic                          out_valid,
	output logic signed [W-1:0]           out_x,
	output logic signed [W-1:0]           out_y,
	output logic [31:0]                   out_z,
	output logic [PW-1:0]                 out_side
);
	import tca_pkg::*;

	logic signed [W-1:0]  x_s [0:STAGES];
	logic signed [W-1:0]  y_s [0:STAGES];
	logic signed [ZW-1:0] z_s [0:STAGES];
	logic                 zero_s [0:STAGES];
	logic                 v_s [0:STAGES];
	logic [PW-1:0]        side_s [0:STAGES];

	logic signed [W-1:0]  pre_x, pre_y;
	logic signed [ZW-1:0] pre_z, zin;
	logic                 pre_zero;

	always_comb begin
		zin      = ZW'($signed(in_z));
		pre_x    = in_x;
		pre_y    = in_y;
		pre_zero = 1'b0;
		if (VEC) begin
			pre_z    = '0;
			pre_zero = (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				pre_x = -in_x;
				pre_y = -in_y;
				pre_z = ZW'(34'sh080000000);
			end
		end else begin
			pre_z = zin;
			if (zin > ZW'(34'sh040000000) || zin < -ZW'(34'sh040000000)) begin
				pre_x = -in_x;
				pre_y = -in_y;
				pre_z = (zin > 0) ? zin - ZW'(34'sh080000000) : zin + ZW'(34'sh080000000);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= pre_x;
			y_s[0]    <= pre_y;
			z_s[0]    <= pre_z;
			zero_s[0] <= pre_zero;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_it
		localparam logic signed [ZW-1:0] ATN = ZW'($signed({2'b00, atan_tab(i)}));
		logic dir;
		assign dir = VEC ? (y_s[i] >= 0) : (z_s[i] >= 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
				if (VEC ? dir : dir) begin
					if (VEC) begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + ATN;
					end else begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - ATN;
					end
				end else begin
					if (VEC) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - ATN;
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + ATN;
					end
				end
			end
		end
	end

	logic [31:0] z_fin;
	assign z_fin = zero_s[STAGES] ? 32'h0 : z_s[STAGES][31:0];

	if (GAIN) begin : g_gain
		localparam int PRW = W + 32;
		logic signed [PRW-1:0] px_s1, py_s1;
		logic signed [W-1:0]   gx_s2, gy_s2;
		logic [31:0]           z_s1, z_s2;
		logic [PW-1:0]         side_s1, side_s2;
		logic                  v_s1, v_s2;
		logic signed [PRW-1:0] rx, ry;

		assign rx = (px_s1 + PRW'(64'sd536870912)) >>> 30;
		assign ry = (py_s1 + PRW'(64'sd536870912)) >>> 30;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else if (en) begin
				v_s1 <= v_s[STAGES];
				v_s2 <= v_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				px_s1   <= PRW'(x_s[STAGES]) * PRW'(INV_GAIN);
				py_s1   <= PRW'(y_s[STAGES]) * PRW'(INV_GAIN);
				z_s1    <= z_fin;
				side_s1 <= side_s[STAGES];
				gx_s2   <= rx[W-1:0];
				gy_s2   <= ry[W-1:0];
				z_s2    <= z_s1;
				side_s2 <= side_s1;
			end
		end

		assign out_valid = v_s2;
		assign out_x     = gx_s2;
		assign out_y     = gy_s2;
		assign out_z     = z_s2;
		assign out_side  = side_s2;
	end else begin : g_nogain
		assign out_valid = v_s[STAGES];
		assign out_x     = x_s[STAGES];
		assign out_y     = y_s[STAGES];
		assign out_z     = z_fin;
		assign out_side  = side_s[STAGES];
	end
endmodule
`default_nettype wire

### src/tilt_compensated_attitude.sv
// Path: input item through the five CORDIC pipelines, then the output register.
// Throughput: one item per cycle; the five CORDIC pipelines stall together
// when a result item waits at the output register.
// Reset: arst_n clears all valid bits; data registers are not reset.
// Top level of the tilt compensated attitude block; uses tca_pkg, tca_cordic.
`default_nettype none
module tilt_compensated_attitude #(
	parameter int SAMPLE_WIDTH  = tca_pkg::SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = tca_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = tca_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, zero pad
	input  wire logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// roll_angle, pitch_angle, yaw_angle
	output logic [3*tca_pkg::ANG_OUT_WIDTH-1:0]        m_tdata
);
	import tca_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int W  = SAMPLE_WIDTH + 4;
	localparam int SH = 32 - ANGLE_WIDTH;

	function automatic logic [ANG_OUT_WIDTH-1:0] out_angle(input logic [31:0] a);
		logic [31:0] rnd;
		logic [31:0] q;
		logic signed [63:0] e;
		rnd = (SH == 0) ? a : a + (32'd1 << (SH - 1));
		q   = rnd >> SH;
		e   = 64'($signed(q[ANGLE_WIDTH-1:0]));
		return e[ANG_OUT_WIDTH-1:0];
	endfunction

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [W-1:0] ax, ay, az, mx, my, mz;
	assign ax = W'($signed(s_tdata[0*SW +: SW]));
	assign ay = W'($signed(s_tdata[1*SW +: SW]));
	assign az = W'($signed(s_tdata[2*SW +: SW]));
	assign mx = W'($signed(s_tdata[3*SW +: SW]));
	assign my = W'($signed(s_tdata[4*SW +: SW]));
	assign mz = W'($signed(s_tdata[5*SW +: SW]));

	// roll: vector (az, -ax); carries ay, mx, my, mz
	logic                c0_valid;
	logic signed [W-1:0] c0_x, c0_y;
	logic [31:0]         c0_z;
	logic [4*W-1:0]      c0_side;
	tca_cordic #(.W(W), .STAGES(CORDIC_STAGES), .VEC(1'b1), .GAIN(1'b1), .PW(4*W)) u_roll (
		.clk, .arst_n, .en, .in_valid(s_tvalid && s_tready),
		.in_x(az), .in_y(-ax), .in_z(32'h0), .in_side({mz, my, mx, ay}),
		.out_valid(c0_valid), .out_x(c0_x), .out_y(c0_y), .out_z(c0_z), .out_side(c0_side)
	);

	// pitch: vector (racc, ay); carries roll, mx, my, mz
	logic                c1_valid;
	logic signed [W-1:0] c1_x, c1_y;
	logic [31:0]         c1_z;
	logic [3*W+31:0]     c1_side;
	tca_cordic #(.W(W), .STAGES(CORDIC_STAGES), .VEC(1'b1), .GAIN(1'b0), .PW(3*W+32)) u_pitch (
		.clk, .arst_n, .en, .in_valid(c0_valid),
		.in_x(c0_x), .in_y(c0_side[0 +: W]), .in_z(32'h0),
		.in_side({c0_z, c0_side[W +: 3*W]}),
		.out_valid(c1_valid), .out_x(c1_x), .out_y(c1_y), .out_z(c1_z), .out_side(c1_side)
	);

	logic signed [W-1:0] p_mx, p_my, p_mz;
	logic [31:0]         p_roll;
	assign p_mx   = c1_side[0 +: W];
	assign p_my   = c1_side[W +: W];
	assign p_mz   = c1_side[2*W +: W];
	assign p_roll = c1_side[3*W +: 32];

	// hx, t: rotate (mx, -mz) by pitch; carries roll, pitch, my
	logic                c2_valid;
	logic signed [W-1:0] c2_x, c2_y;
	logic [31:0]         c2_z;
	logic [W+63:0]       c2_side;
	tca_cordic #(.W(W), .STAGES(CORDIC_STAGES), .VEC(1'b0), .GAIN(1'b1), .PW(W+64)) u_rot_p (
		.clk, .arst_n, .en, .in_valid(c1_valid),
		.in_x(p_mx), .in_y(-p_mz), .in_z(c1_z), .in_side({c1_z, p_roll, p_my}),
		.out_valid(c2_valid), .out_x(c2_x), .out_y(c2_y), .out_z(c2_z), .out_side(c2_side)
	);

	// hy: rotate (my, -t) by roll; carries roll, pitch, hx
	logic                c3_valid;
	logic signed [W-1:0] c3_x, c3_y;
	logic [31:0]         c3_z;
	logic [W+63:0]       c3_side;
	tca_cordic #(.W(W), .STAGES(CORDIC_STAGES), .VEC(1'b0), .GAIN(1'b1), .PW(W+64)) u_rot_r (
		.clk, .arst_n, .en, .in_valid(c2_valid),
		.in_x(c2_side[0 +: W]), .in_y(-c2_y), .in_z(c2_side[W +: 32]),
		.in_side({c2_side[W+32 +: 32], c2_side[W +: 32], c2_x}),
		.out_valid(c3_valid), .out_x(c3_x), .out_y(c3_y), .out_z(c3_z), .out_side(c3_side)
	);

	// yaw: vector (hy, hx); carries roll, pitch
	logic                c4_valid;
	logic signed [W-1:0] c4_x, c4_y;
	logic [31:0]         c4_z;
	logic [63:0]         c4_side;
	tca_cordic #(.W(W), .STAGES(CORDIC_STAGES), .VEC(1'b1), .GAIN(1'b0), .PW(64)) u_yaw (
		.clk, .arst_n, .en, .in_valid(c3_valid),
		.in_x(c3_x), .in_y(c3_side[0 +: W]), .in_z(32'h0), .in_side(c3_side[W +: 64]),
		.out_valid(c4_valid), .out_x(c4_x), .out_y(c4_y), .out_z(c4_z), .out_side(c4_side)
	);

	logic                         out_valid_q;
	logic [3*ANG_OUT_WIDTH-1:0]   out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c4_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {out_angle(c4_z), out_angle(c4_side[63:32]), out_angle(c4_side[31:0])};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	logic unused_ok;
	assign unused_ok = ^{c0_y, c1_x, c1_y, c2_z, c3_y, c3_z, c4_x, c4_y};

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result item changed");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(c4_valid))
		else $error("result item without pipeline source");
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for tilt_compensated_attitude: streams accel/mag vector pairs and
// checks roll, pitch and heading against a fixed-point CORDIC predictor.
// Depends on tca_pkg and the tilt_compensated_attitude RTL.
`timescale 1ns / 1ps

class attitude_scoreboard;
	typedef struct packed {
		logic [15:0] yaw;
		logic [15:0] pitch;
		logic [15:0] roll;
	} angles_t;

	angles_t pending[$];
	int errors = 0;

	static const bit [31:0] ATAN_LUT[16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	function automatic longint unscale(longint v);
		return (v * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic bit [31:0] vec_angle(longint x, longint y, output longint mag);
		bit [31:0] z;
		longint dx, dy;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_LUT[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_LUT[i];
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic void rotate(inout longint x, inout longint y, input bit [31:0] ang);
		longint z, dx, dy;
		z = longint'($signed(ang));
		if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
			x = -x;
			y = -y;
			z = z > 0 ? z - (64'sd1 <<< 31) : z + (64'sd1 <<< 31);
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_LUT[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_LUT[i]);
			end
		end
	endfunction

	function automatic logic [15:0] to_bam(bit [31:0] a);
		bit [31:0] r;
		r = (a + 32'h8000) >> 16;
		return r[15:0];
	endfunction

	function void note(logic [95:0] d);
		longint ax, ay, az, mx, my, mz, racc, tmp, x1, y1, x2, y2;
		bit [31:0] roll, pitch, yaw;
		angles_t e;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		az = longint'($signed(d[47:32]));
		mx = longint'($signed(d[63:48]));
		my = longint'($signed(d[79:64]));
		mz = longint'($signed(d[95:80]));
		roll = vec_angle(az, -ax, racc);
		pitch = vec_angle(unscale(racc), ay, tmp);
		x1 = mx;
		y1 = -mz;
		rotate(x1, y1, pitch);
		x2 = my;
		y2 = -unscale(y1);
		rotate(x2, y2, roll);
		yaw = vec_angle(unscale(x2), unscale(x1), tmp);
		e.roll = to_bam(roll);
		e.pitch = to_bam(pitch);
		e.yaw = to_bam(yaw);
		pending.push_back(e);
	endfunction

	task report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		errors++;
	endtask

	task check(logic [47:0] d);
		angles_t got, want;
		got = d;
		if (pending.size() == 0) begin
			report("unexpected result item, roll", got.roll, '0);
		end else begin
			want = pending.pop_front();
			if (got.roll !== want.roll) report("roll", got.roll, want.roll);
			if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
			if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
		end
	endtask
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;

	attitude_scoreboard sb = new();
	int hold_cnt = 0;
	int burst_left = 0;
	int cycles = 0;

	tilt_compensated_attitude DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 300000) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note(s_tdata);
			if (m_tvalid && m_tready) sb.check(m_tdata);
		end
	end

	initial begin
		int mode;
		int span;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 80);
			end
			span--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 0;
			end else case (mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task send(input logic [95:0] d);
		int gap;
		s_tdata <= d;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [15:0] rnd_in(int lim);
		return 16'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	function automatic logic [95:0] pack6(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
	                                     logic [15:0] mx, logic [15:0] my, logic [15:0] mz);
		return {mz, my, mx, az, ay, ax};
	endfunction

	initial begin
		logic [15:0] v[6];
		int kind;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(pack6(0, 0, 0, 0, 0, 0));
		send(pack6(0, 0, 16'h8000, 0, 0, 0));
		send(pack6(0, 0, 16'h7FFF, 100, 0, 0));
		send(pack6(16'h7FFF, 0, 0, 0, 16'h7FFF, 0));
		send(pack6(16'h8000, 0, 0, 0, 0, 16'h8000));
		send(pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send(pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send(pack6(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send(pack6(0, 16'h7FFF, 0, 16'h7FFF, 0, 16'h7FFF));
		send(pack6(0, 16'h8000, 0, 0, 16'h8000, 0));
		send(pack6(0, 0, 16384, 0, 16'hF000, 0));
		send(pack6(0, 0, 16384, 0, 16'hF000, 1));
		send(pack6(0, 0, 16384, 0, 16'hF000, 16'hFFFF));
		send(pack6(0, 0, 16384, 16'h8000, 0, 0));
		send(pack6(1, 0, 16'hFFFF, 0, 1, 0));
		send(pack6(16'hFFFF, 0, 16'hFFFF, 1, 0, 0));
		send(pack6(0, 0, 16'h8001, 0, 16'h8001, 0));

		hold_cnt = 400;
		for (int n = 0; n < 950; n++) begin
			kind = $urandom_range(0, 2);
			for (int k = 0; k < 6; k++) begin
				case (kind)
					0: v[k] = 16'($urandom_range(0, 65535));
					1: v[k] = rnd_in(k < 3 ? 20000 : 3000);
					default: v[k] = rnd_in($urandom_range(0, 3) == 0 ? 0 : 8);
				endcase
			end
			if (kind == 1) v[2] = 16'(16384 + $signed(rnd_in(4000)));
			send(pack6(v[0], v[1], v[2], v[3], v[4], v[5]));
		end
		s_tvalid <= 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
